// ----- rtl/mcbf_pkg.sv -----
// ----------------------------------------------------------------------------
// mcbf_pkg
// Shared constants and types of the RGBA8 mip-chain box filter.
// ----------------------------------------------------------------------------
package mcbf_pkg;

	localparam int MAX_DIM    = 4096;
	localparam int MAX_LEVELS = 13;
	localparam int NUM_HOLD   = MAX_LEVELS - 1;
	localparam int DIM_W      = 13;
	localparam int CNT_W      = $clog2(MAX_DIM);
	localparam int LVL_W      = 4;
	localparam int POS_W      = 11;
	localparam int CH_W       = 8;
	localparam int SUM_W      = 9;
	localparam int FIFO_DEPTH = 4;

	// register indexes of the configuration port
	typedef enum logic [0:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	// one produced mip pixel
	typedef struct packed {
		logic [LVL_W-1:0] level;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
		logic [CH_W-1:0]  red;
		logic [CH_W-1:0]  green;
		logic [CH_W-1:0]  blue;
		logic [CH_W-1:0]  alpha;
		logic             last;
	} result_t;

endpackage

// ----- rtl/mcbf_out_fifo.sv -----
// ----------------------------------------------------------------------------
// mcbf_out_fifo
// Small result queue between the level engine and the output channel.
// ----------------------------------------------------------------------------
module mcbf_out_fifo import mcbf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    space,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res_data
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);

	result_t            mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     count_q;
	logic               pop;

	assign space     = (count_q != (PTR_W+1)'(FIFO_DEPTH));
	assign res_valid = (count_q != '0);
	assign res_data  = mem_q[rd_ptr_q];
	assign pop       = res_valid && res_ready;

	// store pushed results
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/mip_chain_box_filter_rgba8.sv -----
// ----------------------------------------------------------------------------
// mip_chain_box_filter_rgba8
// Streams every lower mip level of an RGBA8 raster image with a 2x2 box filter.
// ----------------------------------------------------------------------------
// Order: an accepted pixel's pair sums are registered, and the next level step
//   uses them and pushes its result into the output FIFO; each further level follows.
// Throughput: one level step per cycle while the output FIFO has space; a new pixel
//   is accepted only when the level engine holds no pending level step.
// Reset: dimensions return to 1 and all level counters to zero; the row-sum
//   memory is not cleared.
module mip_chain_box_filter_rgba8 import mcbf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// pixel channel
	input  logic                pix_valid,
	output logic                pix_ready,
	input  logic [CH_W-1:0]     red,
	input  logic [CH_W-1:0]     green,
	input  logic [CH_W-1:0]     blue,
	input  logic [CH_W-1:0]     alpha,
	// result channel
	output logic                res_valid,
	input  logic                res_ready,
	output logic [LVL_W-1:0]    level,
	output logic [POS_W-1:0]    col,
	output logic [POS_W-1:0]    row,
	output logic [CH_W-1:0]     out_red,
	output logic [CH_W-1:0]     out_green,
	output logic [CH_W-1:0]     out_blue,
	output logic [CH_W-1:0]     out_alpha,
	output logic                last,
	// configuration
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	// configuration registers
	logic [DIM_W-1:0]            width_q;
	logic [DIM_W-1:0]            height_q;
	logic [DIM_W-1:0]            eff_w;
	logic [DIM_W-1:0]            eff_h;
	logic                        cfg_we;
	reg_idx_t                    cfg_idx;

	// level counters and left-pixel holds
	logic [CNT_W-1:0]            col_cnt_q [MAX_LEVELS];
	logic [CNT_W-1:0]            row_cnt_q [MAX_LEVELS];
	logic [3:0][CH_W-1:0]        hold_q    [NUM_HOLD];

	// row-sum memory
	logic [4*SUM_W-1:0]          sums_mem  [MAX_DIM];
	logic [4*SUM_W-1:0]          rd_q;

	// pending level step
	logic                        busy_q;
	logic [LVL_W-1:0]            lvl_q;
	logic [DIM_W-1:0]            w_q;
	logic [DIM_W-1:0]            h_q;
	logic [CNT_W-1:0]            off_q;
	logic [3:0][SUM_W-1:0]       hs_q;
	logic                        mem_src_q;

	// current step
	logic                        space;
	logic                        step_go;
	logic [LVL_W-1:0]            cur_lvl;
	logic [DIM_W-1:0]            cur_w;
	logic [DIM_W-1:0]            cur_h;
	logic [CNT_W-1:0]            cur_off;
	logic [3:0][CH_W-1:0]        cur_px;
	logic [CNT_W-1:0]            cx;
	logic [CNT_W-1:0]            cy;
	logic [3:0][CH_W-1:0]        hold_rd;
	logic                        single;
	logic                        w_one;
	logic                        h_one;
	logic [CNT_W-1:0]            nw;
	logic [CNT_W-1:0]            nh;
	logic [3:0][SUM_W-1:0]       hs;
	logic                        hv;
	logic [CNT_W-1:0]            hx;
	logic                        hx_ok;
	logic                        vy_ok;
	logic                        mem_sel;
	logic                        mem_we;
	logic                        mem_re;
	logic                        hold_we;
	logic [CNT_W-1:0]            idx;
	logic                        vhave;
	logic                        cont;
	logic                        x_wrap;
	logic                        y_wrap;
	logic                        emit;
	result_t                     push_data;
	result_t                     res_data;

	// register port
	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[2]);
	assign cfg_we  = psel && penable && pwrite;

	always_comb begin
		unique case (cfg_idx)
			REG_WIDTH:  prdata = 32'(width_q);
			REG_HEIGHT: prdata = 32'(height_q);
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(1);
			height_q <= DIM_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				default:    ;
			endcase
		end
	end

	// clamp dimensions into range
	always_comb begin
		eff_w = width_q;
		if (width_q == '0) begin
			eff_w = DIM_W'(1);
		end else if (width_q > DIM_W'(MAX_DIM)) begin
			eff_w = DIM_W'(MAX_DIM);
		end
		eff_h = height_q;
		if (height_q == '0) begin
			eff_h = DIM_W'(1);
		end else if (height_q > DIM_W'(MAX_DIM)) begin
			eff_h = DIM_W'(MAX_DIM);
		end
	end

	// select the step: pending level or a new base pixel
	assign step_go   = space && (busy_q || pix_valid);
	assign pix_ready = space && !busy_q;

	always_comb begin
		if (busy_q) begin
			cur_lvl = lvl_q;
			cur_w   = w_q;
			cur_h   = h_q;
			cur_off = off_q;
			for (int c = 0; c < 4; c++) begin
				if (mem_src_q) begin
					cur_px[c] = CH_W'((10'(rd_q[c*SUM_W +: SUM_W]) + 10'(hs_q[c])) >> 2);
				end else begin
					cur_px[c] = hs_q[c][SUM_W-1:1];
				end
			end
		end else begin
			cur_lvl = '0;
			cur_w   = eff_w;
			cur_h   = eff_h;
			cur_off = '0;
			cur_px  = {alpha, blue, green, red};
		end
	end

	// level step: horizontal pair, vertical pair, memory access
	assign cx      = col_cnt_q[cur_lvl];
	assign cy      = row_cnt_q[cur_lvl];
	assign hold_rd = (cur_lvl < LVL_W'(NUM_HOLD)) ? hold_q[cur_lvl[LVL_W-1:0]] : '0;

	always_comb begin
		single = (cur_w == DIM_W'(1)) && (cur_h == DIM_W'(1));
		w_one  = (cur_w == DIM_W'(1));
		h_one  = (cur_h == DIM_W'(1));
		nw     = (cur_w[DIM_W-1:1] == '0) ? CNT_W'(1) : CNT_W'(cur_w >> 1);
		nh     = (cur_h[DIM_W-1:1] == '0) ? CNT_W'(1) : CNT_W'(cur_h >> 1);
		for (int c = 0; c < 4; c++) begin
			if (w_one) begin
				hs[c] = {cur_px[c], 1'b0};
			end else begin
				hs[c] = SUM_W'(hold_rd[c]) + SUM_W'(cur_px[c]);
			end
		end
		hv      = w_one || cx[0];
		hx      = w_one ? cx : (cx >> 1);
		hx_ok   = (hx < nw);
		vy_ok   = ((cy >> 1) < nh);
		mem_sel = !single && hv && hx_ok && !h_one && vy_ok;
		mem_we  = step_go && mem_sel && !cy[0];
		mem_re  = step_go && mem_sel && cy[0];
		hold_we = step_go && !single && !w_one && !cx[0] && (cur_lvl < LVL_W'(NUM_HOLD));
		idx     = cur_off + hx;
		vhave   = h_one || (vy_ok && cy[0]);
		cont    = !single && hv && hx_ok && vhave && (cur_lvl != LVL_W'(MAX_LEVELS - 1));
		x_wrap  = ((DIM_W'(cx) + DIM_W'(1)) >= cur_w);
		y_wrap  = ((DIM_W'(cy) + DIM_W'(1)) >= cur_h);
	end

	// row-sum memory: write even rows, read odd rows
	always_ff @(posedge clk) begin
		if (mem_we) begin
			sums_mem[idx] <= hs;
		end
		if (mem_re) begin
			rd_q <= sums_mem[idx];
		end
	end

	// hold the left pixel of each level below the last
	always_ff @(posedge clk) begin
		if (hold_we) begin
			hold_q[cur_lvl[LVL_W-1:0]] <= cur_px;
		end
	end

	// advance level counters; drop them back on a register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_LEVELS; i++) begin
				col_cnt_q[i] <= '0;
				row_cnt_q[i] <= '0;
			end
		end else if (cfg_we) begin
			for (int i = 0; i < MAX_LEVELS; i++) begin
				col_cnt_q[i] <= '0;
				row_cnt_q[i] <= '0;
			end
		end else if (step_go) begin
			if (x_wrap) begin
				col_cnt_q[cur_lvl] <= '0;
				row_cnt_q[cur_lvl] <= y_wrap ? '0 : cy + 1'b1;
			end else begin
				col_cnt_q[cur_lvl] <= cx + 1'b1;
			end
		end
	end

	// carry the pair sums to the next level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (cfg_we) begin
			busy_q <= 1'b0;
		end else if (step_go) begin
			busy_q <= cont;
		end
	end

	always_ff @(posedge clk) begin
		if (step_go) begin
			lvl_q     <= cur_lvl + 1'b1;
			w_q       <= DIM_W'(nw);
			h_q       <= DIM_W'(nh);
			off_q     <= cur_off + nw;
			hs_q      <= hs;
			mem_src_q <= !h_one;
		end
	end

	// emit the pixel of every lower level step
	assign emit = step_go && busy_q;

	always_comb begin
		push_data.level = cur_lvl;
		push_data.col   = POS_W'(cx);
		push_data.row   = POS_W'(cy);
		push_data.red   = cur_px[0];
		push_data.green = cur_px[1];
		push_data.blue  = cur_px[2];
		push_data.alpha = cur_px[3];
		push_data.last  = !cont;
	end

	mcbf_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit),
		.push_data (push_data),
		.space     (space),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	assign level     = res_data.level;
	assign col       = res_data.col;
	assign row       = res_data.row;
	assign out_red   = res_data.red;
	assign out_green = res_data.green;
	assign out_blue  = res_data.blue;
	assign out_alpha = res_data.alpha;
	assign last      = res_data.last;

endmodule
